// ===== design/ic3_pkg.sv =====
package ic3_pkg;

  localparam int COEFF_BITS = 8;
  localparam int TAPS       = 9;
  localparam int CENTRE_TAP = 4;
  localparam int ACC_W      = 20;
  localparam int DSUM_W     = 12;
  localparam int DIV_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_UPPER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_LOWER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_TAP   = 3'd5;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] chan_a_in;
    logic [7:0] chan_b_in;
    logic [7:0] chan_c_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] chan_a_out;
    logic [7:0] chan_b_out;
    logic [7:0] chan_c_out;
    logic       frame_end;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MAC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ===== design/image_convolution_3x3_core.sv =====
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_ready  | ic3_pkg::in_beat_t
// out_    | out | out_valid/out_ready| ic3_pkg::out_beat_t
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
// A pixel beat that gives no result passes accept and line store read; one that does
// also passes 9 multiply-accumulate steps, the quotient (start, 20 steps, done)
// and the result load. Flush beats inside a frame are accepted and dropped.
// Reset is synchronous; line stores are not cleared and need no pass.
// A result waiting on out_ready stalls only the result load.
module image_convolution_3x3_core #(
  parameter int MAX_LINE_PIXELS = 2048,
  parameter int MAX_LINES       = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ic3_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ic3_pkg::out_beat_t               out_data,
  input  logic                             cfg_we,
  input  logic [ic3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int W_W   = $clog2(MAX_LINE_PIXELS + 1);
  localparam int H_W   = $clog2(MAX_LINES + 1);
  localparam int TOT_W = W_W + H_W;
  localparam int TAP_W = $clog2(ic3_pkg::TAPS);

  logic        pixel_format_r, single_tap_r;
  logic [11:0] frame_width_r, frame_height_r;
  logic [47:0] coeff_upper_r;
  logic [23:0] coeff_lower_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= 1'b0;
      frame_width_r  <= 12'd640;
      frame_height_r <= 12'd480;
      coeff_upper_r  <= 48'h0001_0000_0000;
      coeff_lower_r  <= '0;
      single_tap_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ic3_pkg::REG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[0];
        ic3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[11:0];
        ic3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[11:0];
        ic3_pkg::REG_COEFF_UPPER:  coeff_upper_r  <= cfg_wdata[47:0];
        ic3_pkg::REG_COEFF_LOWER:  coeff_lower_r  <= cfg_wdata[23:0];
        ic3_pkg::REG_SINGLE_TAP:   single_tap_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [W_W-1:0]   w_sat;
  logic [H_W-1:0]   h_sat;
  logic [TOT_W-1:0] tot_r;

  always_comb begin
    if (frame_width_r == '0) w_sat = W_W'(1);
    else if (32'(frame_width_r) > MAX_LINE_PIXELS) w_sat = W_W'(MAX_LINE_PIXELS);
    else w_sat = W_W'(frame_width_r);
    if (frame_height_r == '0) h_sat = H_W'(1);
    else if (32'(frame_height_r) > MAX_LINES) h_sat = H_W'(MAX_LINES);
    else h_sat = H_W'(frame_height_r);
  end

  always_ff @(posedge clk) tot_r <= TOT_W'(w_sat) * TOT_W'(h_sat);

  ic3_pkg::state_t state_r;
  logic [COL_W-1:0] in_col_r;
  logic [TOT_W-1:0] in_pos_r, out_cnt_r;
  logic [W_W-1:0]   out_x_r;
  logic [H_W-1:0]   out_y_r;
  logic [23:0]      pix_r, rd_up_r, rd_lo_r;
  logic [23:0]      win_r [ic3_pkg::TAPS];
  logic [23:0]      mem_up [MAX_LINE_PIXELS];
  logic [23:0]      mem_lo [MAX_LINE_PIXELS];
  logic [TAP_W-1:0] tap_r;
  logic             interior_r, bypass_r, div_go_r;
  logic signed [ic3_pkg::ACC_W-1:0]  acc_r [3];
  logic signed [ic3_pkg::DSUM_W-1:0] dsum_r;
  logic             out_valid_r;
  ic3_pkg::out_beat_t out_r;

  logic             in_acc, restart, drop, tap_en, emit, load_out, last_out;
  logic [TOT_W-1:0] pos_eff;
  logic [COL_W-1:0] col_eff;
  logic [71:0]      coeff_all;
  logic signed [ic3_pkg::COEFF_BITS-1:0] coeff;
  logic signed [16:0] prod [3];
  logic [ic3_pkg::DIV_W-1:0] divisor;
  logic [ic3_pkg::ACC_W-1:0] dividend [3];
  logic [7:0]       quot [3];
  logic [2:0]       done;

  assign in_ready = state_r == ic3_pkg::S_IDLE;
  assign in_acc   = in_valid && in_ready;
  assign restart  = out_cnt_r >= tot_r;
  assign pos_eff  = restart ? '0 : in_pos_r;
  assign col_eff  = restart ? '0 : in_col_r;
  assign drop     = (in_data.action == ic3_pkg::ACTION_FLUSH) && (pos_eff < tot_r);
  assign emit     = in_pos_r >= TOT_W'(w_sat) + TOT_W'(1);
  assign load_out = (state_r == ic3_pkg::S_OUT) && (!out_valid_r || out_ready);
  assign last_out = out_cnt_r + TOT_W'(1) == tot_r;

  assign coeff_all = {coeff_lower_r, coeff_upper_r};
  assign coeff     = coeff_all[tap_r*ic3_pkg::COEFF_BITS +: ic3_pkg::COEFF_BITS];
  assign tap_en    = interior_r || (tap_r == TAP_W'(ic3_pkg::CENTRE_TAP));
  assign divisor   = (bypass_r || dsum_r <= 0) ? ic3_pkg::DIV_W'(1)
                                              : dsum_r[ic3_pkg::DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && !drop) begin
      rd_up_r <= mem_up[col_eff];
      rd_lo_r <= mem_lo[col_eff];
    end
    if (state_r == ic3_pkg::S_RD) begin
      mem_up[in_col_r] <= rd_lo_r;
      mem_lo[in_col_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !drop) begin
      pix_r <= (pos_eff < tot_r)
               ? {(pixel_format_r ? {in_data.chan_c_in, in_data.chan_b_in} : 16'd0),
                  in_data.chan_a_in}
               : 24'd0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      assign prod[g] = coeff * $signed({1'b0, win_r[tap_r][8*g +: 8]});
      assign dividend[g] = bypass_r ? ic3_pkg::ACC_W'(win_r[ic3_pkg::CENTRE_TAP][8*g +: 8])
                         : (acc_r[g][ic3_pkg::ACC_W-1] ? ic3_pkg::ACC_W'(-acc_r[g])
                                                        : ic3_pkg::ACC_W'(acc_r[g]));
      ic3_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_r),
        .dividend (dividend[g]),
        .divisor  (divisor),
        .done     (done[g]),
        .quot     (quot[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ic3_pkg::S_IDLE;
      in_col_r    <= '0;
      in_pos_r    <= '0;
      out_cnt_r   <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      for (int i = 0; i < ic3_pkg::TAPS; i++) win_r[i] <= '0;
    end else begin
      div_go_r <= (state_r == ic3_pkg::S_MAC) && (tap_r == TAP_W'(ic3_pkg::TAPS - 1));
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ic3_pkg::S_IDLE: begin
          if (in_acc) begin
            if (restart) begin
              in_col_r  <= '0;
              in_pos_r  <= '0;
              out_cnt_r <= '0;
              out_x_r   <= '0;
              out_y_r   <= '0;
            end
            if (!drop) state_r <= ic3_pkg::S_RD;
          end
        end
        ic3_pkg::S_RD: begin
          for (int r = 0; r < 3; r++) begin
            win_r[3*r]   <= win_r[3*r+1];
            win_r[3*r+1] <= win_r[3*r+2];
          end
          win_r[2] <= rd_up_r;
          win_r[5] <= rd_lo_r;
          win_r[8] <= pix_r;
          in_pos_r <= in_pos_r + TOT_W'(1);
          if (W_W'(in_col_r) + W_W'(1) >= w_sat) in_col_r <= '0;
          else in_col_r <= in_col_r + COL_W'(1);
          interior_r <= !single_tap_r && (out_x_r != '0) && (out_y_r != '0)
                        && ({1'b0, out_x_r} + (W_W+1)'(2) <= {1'b0, w_sat})
                        && ({1'b0, out_y_r} + (H_W+1)'(2) <= {1'b0, h_sat});
          bypass_r   <= !single_tap_r && !((out_x_r != '0) && (out_y_r != '0)
                        && ({1'b0, out_x_r} + (W_W+1)'(2) <= {1'b0, w_sat})
                        && ({1'b0, out_y_r} + (H_W+1)'(2) <= {1'b0, h_sat}));
          tap_r  <= '0;
          dsum_r <= '0;
          for (int c = 0; c < 3; c++) acc_r[c] <= '0;
          state_r <= emit ? ic3_pkg::S_MAC : ic3_pkg::S_IDLE;
        end
        ic3_pkg::S_MAC: begin
          if (tap_en) begin
            for (int c = 0; c < 3; c++) acc_r[c] <= acc_r[c] + ic3_pkg::ACC_W'(prod[c]);
            dsum_r <= dsum_r + ic3_pkg::DSUM_W'(coeff);
          end
          if (tap_r == TAP_W'(ic3_pkg::TAPS - 1)) begin
            state_r  <= ic3_pkg::S_DIV;
          end else begin
            tap_r <= tap_r + TAP_W'(1);
          end
        end
        ic3_pkg::S_DIV: begin
          if (&done) state_r <= ic3_pkg::S_OUT;
        end
        ic3_pkg::S_OUT: begin
          if (load_out) begin
            state_r     <= ic3_pkg::S_IDLE;
            if (last_out) begin
              in_col_r  <= '0;
              in_pos_r  <= '0;
              out_cnt_r <= '0;
              out_x_r   <= '0;
              out_y_r   <= '0;
            end else begin
              out_cnt_r <= out_cnt_r + TOT_W'(1);
              if (out_x_r + W_W'(1) >= w_sat) begin
                out_x_r <= '0;
                out_y_r <= out_y_r + H_W'(1);
              end else begin
                out_x_r <= out_x_r + W_W'(1);
              end
            end
          end
        end
        default: state_r <= ic3_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.chan_a_out <= quot[0];
      out_r.chan_b_out <= pixel_format_r ? quot[1] : 8'd0;
      out_r.chan_c_out <= pixel_format_r ? quot[2] : 8'd0;
      out_r.frame_end  <= last_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/ic3_div.sv =====
module ic3_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ic3_pkg::ACC_W-1:0]   dividend,
  input  logic [ic3_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [7:0]                  quot
);

  localparam int CNT_W = $clog2(ic3_pkg::ACC_W);

  logic [CNT_W-1:0]            cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [ic3_pkg::DIV_W-1:0]   rem_r;
  logic [ic3_pkg::DIV_W-1:0]   d_r;
  logic [ic3_pkg::ACC_W-1:0]   q_r;
  logic [ic3_pkg::DIV_W:0]     trial;
  logic                        fits;

  assign trial = {rem_r, q_r[ic3_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(ic3_pkg::ACC_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      rem_r <= fits ? ic3_pkg::DIV_W'(trial - {1'b0, d_r}) : trial[ic3_pkg::DIV_W-1:0];
      q_r   <= {q_r[ic3_pkg::ACC_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = (|q_r[ic3_pkg::ACC_W-1:8]) ? 8'hFF : q_r[7:0];

endmodule

// ===== design/ic3_checker.sv =====
module ic3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ic3_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ic3_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.action == ic3_pkg::ACTION_PIXEL) |=> !in_ready)
    else $error("input taken while a pixel beat is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without work in progress");

endmodule

bind image_convolution_3x3_core ic3_checker u_ic3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_image_convolution_3x3_core.sv =====
module tb_image_convolution_3x3_core;

  localparam int LINE_MAX = 2048;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ic3_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  ic3_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [ic3_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ic3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  image_convolution_3x3_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // register mirror
  logic        fmt_rgb;
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [47:0] coeff_hi;
  logic [23:0] coeff_lo;
  logic        centre_only;

  // filter state
  logic [23:0] row_above [LINE_MAX];
  logic [23:0] row_prev [LINE_MAX];
  logic [23:0] win [3][3];
  int unsigned col_pos;
  int unsigned row_pos;
  longint unsigned pixels_out;

  ic3_pkg::in_beat_t pending_beats[$];
  ic3_pkg::out_beat_t expected_pixels[$];
  int idle_pct;
  int stall_pct;
  int mismatches = 0;
  int items_sent;
  int unsigned cycles = 0;

  function automatic longint coeff_at(int k);
    logic [7:0] raw;
    if (k < 6) raw = coeff_hi[8*k +: 8];
    else raw = coeff_lo[8*(k-6) +: 8];
    return longint'($signed(raw));
  endfunction

  function automatic logic [7:0] scale_clip(longint s, longint d);
    longint unsigned mag;
    mag = (s < 0) ? longint'(-s) : s;
    if (d > 0) mag = mag / longint'(d);
    return (mag > 255) ? 8'd255 : mag[7:0];
  endfunction

  function automatic void filter_restart();
    col_pos = 0;
    row_pos = 0;
    pixels_out = 0;
  endfunction

  function automatic void convolve_beat(ic3_pkg::in_beat_t b);
    longint unsigned w, h, tot, pos, y, x;
    logic [23:0] pix, upper, mid, centre;
    logic interior;
    ic3_pkg::out_beat_t r;
    logic [7:0] v [3];
    longint s, d;
    w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > LINE_MAX ? LINE_MAX : height_reg);
    tot = w * h;
    pix = '0;
    if (pixels_out >= tot) filter_restart();
    pos = row_pos * w + col_pos;
    if (b.action == ic3_pkg::ACTION_FLUSH && pos < tot) return;
    if (pos < tot) begin
      pix[7:0] = b.chan_a_in;
      if (fmt_rgb) pix[23:8] = {b.chan_c_in, b.chan_b_in};
    end
    upper = row_above[col_pos % LINE_MAX];
    mid = row_prev[col_pos % LINE_MAX];
    row_above[col_pos % LINE_MAX] = mid;
    row_prev[col_pos % LINE_MAX] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper;
    win[1][2] = mid;
    win[2][2] = pix;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (pos < w + 1) return;
    y = pixels_out / w;
    x = pixels_out % w;
    interior = !centre_only && x >= 1 && x + 2 <= w && y >= 1 && y + 2 <= h;
    centre = win[1][1];
    for (int ch = 0; ch < 3; ch++) begin
      if (ch > 0 && !fmt_rgb) begin
        v[ch] = 8'd0;
      end else if (centre_only) begin
        v[ch] = scale_clip(coeff_at(4) * longint'(centre[8*ch +: 8]), coeff_at(4));
      end else if (interior) begin
        s = 0;
        d = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            s += coeff_at(3*i + j) * longint'(win[i][j][8*ch +: 8]);
            d += coeff_at(3*i + j);
          end
        v[ch] = scale_clip(s, d);
      end else begin
        v[ch] = centre[8*ch +: 8];
      end
    end
    r.chan_a_out = v[0];
    r.chan_b_out = v[1];
    r.chan_c_out = v[2];
    r.frame_end = (pixels_out + 1 == tot);
    expected_pixels.push_back(r);
    pixels_out++;
    if (pixels_out >= tot) filter_restart();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    ic3_pkg::out_beat_t want;
    if (rst_n && in_valid && in_ready) convolve_beat(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.chan_a_out !== want.chan_a_out
            || out_data.chan_b_out !== want.chan_b_out
            || out_data.chan_c_out !== want.chan_c_out
            || out_data.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected a=%h b=%h c=%h end=%b got a=%h b=%h c=%h end=%b",
                     want.chan_a_out, want.chan_b_out, want.chan_c_out, want.frame_end,
                     out_data.chan_a_out, out_data.chan_b_out, out_data.chan_c_out,
                     out_data.frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_quiet();
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ic3_pkg::CFG_IDX_W-1:0] idx,
                           logic [ic3_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      ic3_pkg::REG_PIXEL_FORMAT: fmt_rgb = val[0];
      ic3_pkg::REG_FRAME_WIDTH:  width_reg = val[11:0];
      ic3_pkg::REG_FRAME_HEIGHT: height_reg = val[11:0];
      ic3_pkg::REG_COEFF_UPPER:  coeff_hi = val[47:0];
      ic3_pkg::REG_COEFF_LOWER:  coeff_lo = val[23:0];
      ic3_pkg::REG_SINGLE_TAP:   centre_only = val[0];
      default: ;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_frame(logic rgb, int w, int h, logic [47:0] hi, logic [23:0] lo,
                           logic single);
    wait_quiet();
    write_reg(ic3_pkg::REG_PIXEL_FORMAT, ic3_pkg::CFG_DATA_W'(rgb));
    write_reg(ic3_pkg::REG_FRAME_WIDTH, ic3_pkg::CFG_DATA_W'(w));
    write_reg(ic3_pkg::REG_FRAME_HEIGHT, ic3_pkg::CFG_DATA_W'(h));
    write_reg(ic3_pkg::REG_COEFF_UPPER, ic3_pkg::CFG_DATA_W'(hi));
    write_reg(ic3_pkg::REG_COEFF_LOWER, ic3_pkg::CFG_DATA_W'(lo));
    write_reg(ic3_pkg::REG_SINGLE_TAP, ic3_pkg::CFG_DATA_W'(single));
    cfg_we <= 1'b0;
  endtask

  function automatic ic3_pkg::in_beat_t any_pixel(logic act);
    ic3_pkg::in_beat_t b;
    b.action = act;
    b.chan_a_in = 8'($urandom_range(255));
    b.chan_b_in = 8'($urandom_range(255));
    b.chan_c_in = 8'($urandom_range(255));
    return b;
  endfunction

  // full frame, stray flushes inside, then drain with flushes or pixels whose data is ignored
  task automatic send_frame(int w, int h, bit hold_mid);
    int n;
    n = w * h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) pending_beats.push_back(any_pixel(ic3_pkg::ACTION_FLUSH));
      pending_beats.push_back(any_pixel(ic3_pkg::ACTION_PIXEL));
      if (hold_mid && i == n / 2) wait_quiet();
    end
    for (int i = 0; i <= w; i++)
      pending_beats.push_back(any_pixel($urandom_range(3) != 0 ? ic3_pkg::ACTION_FLUSH
                                                                : ic3_pkg::ACTION_PIXEL));
    items_sent += n + w + 1;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    ic3_pkg::in_beat_t b;
    int goal;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    fmt_rgb = 1'b0;
    width_reg = 12'd640;
    height_reg = 12'd480;
    coeff_hi = 48'h0001_0000_0000;
    coeff_lo = '0;
    centre_only = 1'b1;
    for (int i = 0; i < LINE_MAX; i++) begin
      row_above[i] = '0;
      row_prev[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    filter_restart();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 gray, full kernel at +127: only the centre is interior
    set_frame(1'b0, 3, 3, {6{8'h7f}}, {3{8'h7f}}, 1'b0);
    for (int i = 0; i < 9; i++) begin
      b = any_pixel(ic3_pkg::ACTION_PIXEL);
      b.chan_a_in = (i % 2) ? 8'hff : 8'h00;
      b.chan_b_in = 8'hff;
      b.chan_c_in = 8'hff;
      pending_beats.push_back(b);
      if (i == 4) pending_beats.push_back(any_pixel(ic3_pkg::ACTION_FLUSH));
    end
    b = any_pixel(ic3_pkg::ACTION_PIXEL);
    b.chan_a_in = 8'hff;
    pending_beats.push_back(b);
    repeat (3) pending_beats.push_back(any_pixel(ic3_pkg::ACTION_FLUSH));
    // RGB 3x3, kernel all -128 (negative sum), then zero sum and single tap -128
    set_frame(1'b1, 3, 3, {6{8'h80}}, {3{8'h80}}, 1'b0);
    send_frame(3, 3, 1'b0);
    set_frame(1'b1, 3, 3, 48'h01ff_01ff_01ff, 24'h00ff_01, 1'b0);
    send_frame(3, 3, 1'b0);
    set_frame(1'b1, 2, 2, 48'h0080_0000_0000, 24'h0, 1'b1);
    send_frame(2, 2, 1'b0);
    // zero sizes saturate to one
    set_frame(1'b1, 0, 3, rand48(), 24'($urandom), 1'b0);
    send_frame(1, 3, 1'b0);
    set_frame(1'b0, 5, 0, rand48(), 24'($urandom), 1'b0);
    send_frame(5, 1, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 15) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 15) : 0;
      goal = items_sent + 100;
      while (items_sent < goal) begin
        int w, h;
        logic [47:0] hi;
        logic [23:0] lo;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        hi = rand48();
        lo = 24'($urandom);
        if ($urandom_range(3) == 0) begin
          // small coefficients, from -3 to +3, keep the sums small
          for (int k = 0; k < 6; k++) hi[8*k +: 8] = 8'($signed($urandom_range(0, 6)) - 3);
          for (int k = 0; k < 3; k++) lo[8*k +: 8] = 8'($signed($urandom_range(0, 6)) - 3);
        end
        set_frame(1'($urandom_range(1)), w, h, hi, lo, $urandom_range(3) == 0);
        send_frame(w, h, items_sent > goal - 60 && items_sent < goal - 30);
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
